// File: hdl/gba_pkg.sv
// Shared constants and types for the granule bitmap allocator.
// No dependencies; imported by granule_bitmap_allocator_core.
`default_nettype none

package gba_pkg;

	localparam int MAX_GRANULES = 1024;
	localparam int MAX_RUN      = 32;
	localparam int MAP_WORDS    = (MAX_GRANULES + 31) / 32;
	localparam int WORD_W       = 32;
	localparam int IDX_W        = $clog2(MAP_WORDS);
	localparam int GRAN_W       = $clog2(MAX_GRANULES);
	localparam int CNT_W        = GRAN_W + 1;
	localparam int RUN_W        = $clog2(MAX_RUN) + 1;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_HEAP_BASE     = 2'd0,
		REG_GRANULE_SHIFT = 2'd1,
		REG_GRANULE_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_RUN    = 2'd1,
		ST_BAD       = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_PREP  = 11'b000_0000_0010,
		S_RANGE = 11'b000_0000_0100,
		S_SCAN  = 11'b000_0000_1000,
		S_RDLO  = 11'b000_0001_0000,
		S_RDHI  = 11'b000_0010_0000,
		S_FCHK  = 11'b000_0100_0000,
		S_WRLO  = 11'b000_1000_0000,
		S_WRHI  = 11'b001_0000_0000,
		S_ADDR  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

endpackage

`default_nettype wire

// File: hdl/granule_bitmap_allocator_core.sv
// Granule bitmap allocator: first-fit allocate and free of granule runs.
// Depends on gba_pkg for constants, codes and the sequencer state type.
`default_nettype none

// Allocates runs of 1 to 32 contiguous granules out of a heap of up to 1024
// granules tracked by a 32 x 32 bitmap (one bit per granule, cleared by
// reset). Each item on the input stream is one request: tuser picks allocate
// or free. An allocate rounds byte_size up to whole granules and takes the
// lowest run of free granules that lies below granule_count, returning
// heap_base + (index << granule_shift). A free clears a run that must be
// fully allocated. Exactly one result item comes back per request, with a
// status code and the granted address (zero unless an allocate succeeded).
// Timing: one request at a time; the input is not ready while a request is
// in progress. An allocate walks the bitmap one word per cycle through a
// single run-fit checker, from word 0 until a run fits or the last word
// has been seen. A free reads the two words that its run can touch,
// checks them and writes them back; it skips the write when the run is not
// all allocated and the bitmap when the run reaches past the heap, and a
// rejected request goes straight to its result. A finished result waits
// for the previous one to leave the output register. A finished result
// sits in that register, so the next request can be accepted while the
// previous result is still waiting to be taken. Configuration writes take
// effect at once and must only happen while the block is idle.
module granule_bitmap_allocator_core
	import gba_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [29:0] byte_size, [61:30] free_address
	input  wire logic        s_axis_tuser,   // [0] req_type
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] grant_address
	output logic [1:0]       m_axis_tuser    // [1:0] status
);

	// configuration
	logic [31:0]      heap_base_q;
	logic [4:0]       granule_shift_q;
	logic [CNT_W-1:0] granule_count_q;
	logic [CNT_W-1:0] count_lim;

	// request
	req_t             req_q;
	logic [29:0]      size_q;
	logic [31:0]      addr_q;

	// sequencer
	state_t           state_q;
	logic [RUN_W-1:0] n_q;
	logic [31:0]      nmask_q;
	logic [31:0]      diff_q;
	logic [GRAN_W-1:0] g_q;
	logic [IDX_W:0]   scan_k_q;
	logic [31:0]      prev_q;
	logic [31:0]      lo_q;
	logic [31:0]      hi_q;
	status_t          status_q;
	logic [31:0]      grant_q;

	// bitmap
	logic [31:0]      map_q [MAP_WORDS];

	// output register
	logic             out_valid_q;
	status_t          out_status_q;
	logic [31:0]      out_grant_q;

	// combinational helpers
	logic             shift_ok;
	logic [35:0]      size_max;
	logic             size_bad;
	logic [30:0]      size_round;
	logic [RUN_W-1:0] n_calc;
	logic [31:0]      gi;
	logic [32:0]      gi_end;
	logic [IDX_W-1:0] lo_idx;
	logic [IDX_W:0]   hi_idx;
	logic [IDX_W:0]   lim_word;
	logic [31:0]      lim_mask;
	logic [31:0]      cur_word;
	logic [63:0]      win;
	logic [31:0]      fit;
	logic             fit_any;
	logic [4:0]       fit_pos;
	logic [63:0]      run_mask;
	logic [63:0]      free_win;
	logic             free_ok;
	logic             done_go;

	assign count_lim = (granule_count_q > CNT_W'(MAX_GRANULES)) ?
		CNT_W'(MAX_GRANULES) : granule_count_q;

	assign shift_ok   = (granule_shift_q >= 5'd1) && (granule_shift_q <= 5'd24);
	assign size_max   = 36'(MAX_RUN) << granule_shift_q;
	assign size_bad   = (size_q == '0) || ({6'd0, size_q} > size_max);
	// round up to whole granules
	assign size_round = {1'b0, size_q} + ((31'd1 << granule_shift_q) - 31'd1);
	assign n_calc     = RUN_W'(size_round >> granule_shift_q);

	assign gi     = diff_q >> granule_shift_q;
	assign gi_end = {1'b0, gi} + 33'(n_q);

	assign lo_idx = g_q[GRAN_W-1:5];
	assign hi_idx = {1'b0, lo_idx} + 1'b1;

	// granules at or past the heap limit read as allocated
	assign lim_word = count_lim[CNT_W-1:5];
	always_comb begin
		if (scan_k_q < lim_word) begin
			lim_mask = '0;
		end else if (scan_k_q == lim_word) begin
			lim_mask = ~((32'd1 << count_lim[4:0]) - 32'd1);
		end else begin
			lim_mask = ALL_ONES;
		end
	end

	// run-fit checker used by the allocate scan: starts in word k-1, window spans words k-1 and k
	assign cur_word = ((scan_k_q < (IDX_W+1)'(MAP_WORDS)) ?
		map_q[scan_k_q[IDX_W-1:0]] : ALL_ONES) | lim_mask;
	assign win = {cur_word, prev_q};

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			fit[i] = ~|(win[i +: 32] & nmask_q);
		end
	end

	always_comb begin
		fit_pos = '0;
		for (int i = 31; i >= 0; i--) begin
			if (fit[i]) begin
				fit_pos = 5'(i);
			end
		end
	end
	assign fit_any = |fit;

	assign run_mask = {32'd0, nmask_q} << g_q[4:0];
	assign free_win = {hi_q, lo_q} >> g_q[4:0];
	assign free_ok  = (free_win[31:0] & nmask_q) == nmask_q;

	assign done_go = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_grant_q;
	assign m_axis_tuser  = out_status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q     <= '0;
			granule_shift_q <= 5'd6;
			granule_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAP_BASE:     heap_base_q     <= cfg_data;
				REG_GRANULE_SHIFT: granule_shift_q <= cfg_data[4:0];
				REG_GRANULE_COUNT: granule_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// bitmap: one word written per cycle, set on allocate, cleared on free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < MAP_WORDS; w++) begin
				map_q[w] <= '0;
			end
		end else if (state_q == S_WRLO) begin
			map_q[lo_idx] <= (req_q == REQ_ALLOC) ?
				(map_q[lo_idx] | run_mask[31:0]) : (map_q[lo_idx] & ~run_mask[31:0]);
		end else if ((state_q == S_WRHI) && (hi_idx < (IDX_W+1)'(MAP_WORDS))) begin
			map_q[hi_idx[IDX_W-1:0]] <= (req_q == REQ_ALLOC) ?
				(map_q[hi_idx[IDX_W-1:0]] | run_mask[63:32]) :
				(map_q[hi_idx[IDX_W-1:0]] & ~run_mask[63:32]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (!shift_ok || size_bad) begin
						state_q <= S_DONE;
					end else if (req_q == REQ_ALLOC) begin
						state_q <= S_SCAN;
					end else if (addr_q < heap_base_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RANGE;
					end
				end
				S_RANGE: begin
					state_q <= (gi_end > 33'(count_lim)) ? S_DONE : S_RDLO;
				end
				S_SCAN: begin
					if (scan_k_q != '0 && fit_any) begin
						state_q <= S_WRLO;
					end else if (scan_k_q == (IDX_W+1)'(MAP_WORDS)) begin
						state_q <= S_DONE;
					end
				end
				S_RDLO: state_q <= S_RDHI;
				S_RDHI: state_q <= S_FCHK;
				S_FCHK: state_q <= free_ok ? S_WRLO : S_DONE;
				S_WRLO: state_q <= S_WRHI;
				S_WRHI: state_q <= (req_q == REQ_ALLOC) ? S_ADDR : S_DONE;
				S_ADDR: state_q <= S_DONE;
				S_DONE: begin
					if (done_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q    <= req_t'(s_axis_tuser);
				size_q   <= s_axis_tdata[29:0];
				addr_q   <= s_axis_tdata[61:30];
				grant_q  <= '0;
				status_q <= ST_BAD;
			end
			S_PREP: begin
				n_q      <= n_calc;
				nmask_q  <= ALL_ONES >> (RUN_W'(MAX_RUN) - n_calc);
				diff_q   <= addr_q - heap_base_q;
				scan_k_q <= '0;
				status_q <= ST_BAD;
			end
			S_RANGE: begin
				g_q <= gi[GRAN_W-1:0];
			end
			S_SCAN: begin
				prev_q   <= cur_word;
				scan_k_q <= scan_k_q + 1'b1;
				if (scan_k_q != '0 && fit_any) begin
					g_q      <= {scan_k_q[IDX_W-1:0] - 1'b1, fit_pos};
					status_q <= ST_OK;
				end else begin
					status_q <= ST_NO_RUN;
				end
			end
			S_RDLO: begin
				lo_q <= map_q[lo_idx];
			end
			S_RDHI: begin
				hi_q <= (hi_idx < (IDX_W+1)'(MAP_WORDS)) ? map_q[hi_idx[IDX_W-1:0]] : ALL_ONES;
			end
			S_FCHK: begin
				status_q <= free_ok ? ST_OK : ST_NOT_ALLOC;
			end
			S_ADDR: begin
				grant_q <= heap_base_q + ({{(32-GRAN_W){1'b0}}, g_q} << granule_shift_q);
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_status_q <= status_q;
			out_grant_q  <= grant_q;
		end
	end

endmodule

`default_nettype wire
